FILE: hdl/stereo_disparity_ssd_macros.svh
// ----------------------------------------------------------------------------
// stereo_disparity_ssd_macros
// assertion helpers shared by the stereo disparity block
// ----------------------------------------------------------------------------
`ifndef STEREO_DISPARITY_SSD_MACROS_SVH
`define STEREO_DISPARITY_SSD_MACROS_SVH

// same-cycle implication, quiet during reset
`define SDS_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define SDS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// shared widths, codes and types of the stereo disparity block
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 9;
    localparam int OFF_W    = 8;
    localparam int COST_W   = 27;
    localparam int RADIUS_W = 3;
    localparam int SIZE_W   = 10;

    // cost reported when no candidate column exists
    localparam logic [COST_W-1:0] NO_MATCH_COST = 27'd99999999;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_RADIUS     = 3'd0,
        REG_MIN_OFFSET = 3'd1,
        REG_MAX_OFFSET = 3'd2,
        REG_WIDTH      = 3'd3,
        REG_HEIGHT     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [RADIUS_W-1:0]      radius;
        logic signed [OFF_W-1:0]  min_offset;
        logic signed [OFF_W-1:0]  max_offset;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        radius:     3'd1,
        min_offset: -8'sd64,
        max_offset: 8'sd0,
        width:      10'd512,
        height:     10'd512
    };

    // marks that travel with each window pixel
    typedef struct packed {
        logic                    head;    // first pixel of a candidate window
        logic                    tail;    // last pixel of a candidate window
        logic                    done;    // last pixel of the whole query
        logic signed [OFF_W-1:0] offset;  // candidate offset from the query column
    } tag_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic ready;  // idle, takes an item
        logic init;   // clear the running best
        logic load;   // move the best match into the output register
    } seq_stat_t;

endpackage

FILE: hdl/sds_if.sv
// ----------------------------------------------------------------------------
// sds_if
// valid/ready channels of the stereo disparity block
// ----------------------------------------------------------------------------
interface sds_cmd_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [sds_pkg::COORD_W-1:0]      col;
    logic [sds_pkg::COORD_W-1:0]      row;
    logic [sds_pkg::PIX_W-1:0]        left_pixel;
    logic [sds_pkg::PIX_W-1:0]        right_pixel;

    modport source (output valid, op, col, row, left_pixel, right_pixel, input ready);
    modport sink   (input valid, op, col, row, left_pixel, right_pixel, output ready);
endinterface

interface sds_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [sds_pkg::OFF_W-1:0] disparity;
    logic [sds_pkg::COST_W-1:0]       best_cost;

    modport source (output valid, disparity, best_cost, input ready);
    modport sink   (input valid, disparity, best_cost, output ready);
endinterface

FILE: hdl/sds_frame_store.sv
// ----------------------------------------------------------------------------
// sds_frame_store
// single-port pixel memory with registered read data
// ----------------------------------------------------------------------------
module sds_frame_store #(
    parameter int DEPTH = 262144
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(DEPTH)-1:0]       addr,
    input  logic [sds_pkg::PIX_W-1:0]      wdata,
    output logic [sds_pkg::PIX_W-1:0]      rdata
);

    logic [sds_pkg::PIX_W-1:0] mem [DEPTH];
    logic [sds_pkg::PIX_W-1:0] rdata_reg;

    // write on store, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sds_ssd_unit.sv
// ----------------------------------------------------------------------------
// sds_ssd_unit
// shared squared-difference unit, window accumulator and best-match keeper
// ----------------------------------------------------------------------------
module sds_ssd_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              init,
    input  logic                              in_valid,
    input  logic [sds_pkg::PIX_W-1:0]         left_px,
    input  logic [sds_pkg::PIX_W-1:0]         right_px,
    input  sds_pkg::tag_t                     in_tag,
    output logic [sds_pkg::COST_W-1:0]        best_cost,
    output logic signed [sds_pkg::OFF_W-1:0]  best_off,
    output logic                              fin
);

    localparam int SQ_W = 2 * sds_pkg::PIX_W;

    logic signed [sds_pkg::PIX_W:0]       diff;
    logic signed [2*sds_pkg::PIX_W+1:0]   prod;
    logic [SQ_W-1:0]                      sq_next;
    logic [SQ_W-1:0]                      sq_reg;
    logic                                 sq_valid_reg;
    sds_pkg::tag_t                        sq_tag_reg;

    logic [sds_pkg::COST_W-1:0]           acc_next;
    logic [sds_pkg::COST_W-1:0]           acc_reg;
    logic [sds_pkg::COST_W-1:0]           sum_reg;
    logic                                 sum_valid_reg;
    logic                                 sum_done_reg;
    logic signed [sds_pkg::OFF_W-1:0]     sum_off_reg;

    logic [sds_pkg::COST_W-1:0]           best_reg;
    logic signed [sds_pkg::OFF_W-1:0]     best_off_reg;
    logic                                 fin_reg;

    // squared difference of one pixel pair
    always_comb
    begin
        diff    = $signed({1'b0, left_px}) - $signed({1'b0, right_px});
        prod    = diff * diff;
        sq_next = prod[SQ_W-1:0];
    end

    // window sum restarts on the first pixel of each candidate
    always_comb
    begin
        acc_next = (sq_tag_reg.head ? '0 : acc_reg) + sds_pkg::COST_W'(sq_reg);
    end

    // valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg && sq_tag_reg.tail;
            fin_reg       <= sum_valid_reg && sum_done_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_next;
        sq_tag_reg <= in_tag;
        if (sq_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        sum_reg      <= acc_next;
        sum_done_reg <= sq_tag_reg.done;
        sum_off_reg  <= sq_tag_reg.offset;
        // strictly smaller cost wins, so the lowest offset keeps a tie
        if (init)
        begin
            best_reg     <= sds_pkg::NO_MATCH_COST;
            best_off_reg <= '0;
        end
        else if (sum_valid_reg && (sum_reg < best_reg))
        begin
            best_reg     <= sum_reg;
            best_off_reg <= sum_off_reg;
        end
    end

    assign best_cost = best_reg;
    assign best_off  = best_off_reg;
    assign fin       = fin_reg;

endmodule

FILE: hdl/sds_seq.sv
// ----------------------------------------------------------------------------
// sds_seq
// query sequencer: walks candidate columns and window pixels, issues reads
// ----------------------------------------------------------------------------
module sds_seq #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_RADIUS = 7
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [sds_pkg::COORD_W-1:0]                   q_col,
    input  logic [sds_pkg::COORD_W-1:0]                   q_row,
    input  sds_pkg::cfg_t                                 cfg,
    input  logic                                          fin,
    input  logic                                          slot_free,
    output sds_pkg::seq_stat_t                            stat,
    output logic                                          rd_valid,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       rd_addr_l,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       rd_addr_r,
    output sds_pkg::tag_t                                 rd_tag
);

    localparam int CW = $clog2(MAX_WIDTH + 1024) + 1;
    localparam int RS = $clog2(MAX_RADIUS + 1) + 1;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;

    logic signed [CW-1:0]   col_reg, row_reg, wl1_reg, hl1_reg;
    logic signed [CW-1:0]   wl1_next, hl1_next;
    logic signed [RS-1:0]   r_reg, r_next;
    logic signed [CW-1:0]   hi_reg, hi_next;
    logic signed [CW-1:0]   d_reg, d_next;
    logic signed [RS-1:0]   wx_reg, wx_next, wy_reg, wy_next;

    logic signed [CW-1:0]   w_sel, h_sel;
    logic signed [CW-1:0]   lo_raw, hi_raw, hi_lim, neg_r, lo;
    logic                   empty;

    logic signed [CW-1:0]   y_raw, xl_raw, xr_raw;
    sds_pkg::tag_t          tag_now;

    logic                   a_valid_reg;
    logic [YW-1:0]          a_y_reg;
    logic [XW-1:0]          a_xl_reg, a_xr_reg;
    sds_pkg::tag_t          a_tag_reg;

    logic                   b_valid_reg;
    logic [AW-1:0]          b_addr_l_reg, b_addr_r_reg;
    sds_pkg::tag_t          b_tag_reg;

    // clamp a coordinate to [0, lim]
    function automatic logic [CW-1:0] clamp_coord(input logic signed [CW-1:0] v,
                                                 input logic signed [CW-1:0] lim);
        logic [CW-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > lim)
            res = lim;
        else
            res = v;
        return res;
    endfunction

    // frame size and radius saturated to what the stores hold
    always_comb
    begin
        if (cfg.width == '0)
            w_sel = CW'(1);
        else if (int'(cfg.width) > MAX_WIDTH)
            w_sel = CW'(MAX_WIDTH);
        else
            w_sel = CW'(cfg.width);
        if (cfg.height == '0)
            h_sel = CW'(1);
        else if (int'(cfg.height) > MAX_HEIGHT)
            h_sel = CW'(MAX_HEIGHT);
        else
            h_sel = CW'(cfg.height);
        wl1_next = w_sel - CW'(1);
        hl1_next = h_sel - CW'(1);
        r_next   = (int'(cfg.radius) > MAX_RADIUS) ? RS'(MAX_RADIUS) : RS'(cfg.radius);
    end

    // candidate column range
    always_comb
    begin
        lo_raw  = col_reg + CW'(cfg.min_offset);
        hi_raw  = col_reg + CW'(cfg.max_offset);
        neg_r   = -CW'(r_reg);
        hi_lim  = wl1_reg + CW'(r_reg);
        lo      = (lo_raw < neg_r) ? neg_r : lo_raw;
        hi_next = (hi_raw > hi_lim) ? hi_lim : hi_raw;
        empty   = lo > hi_next;
    end

    // current window pixel and its marks
    always_comb
    begin
        y_raw          = row_reg + CW'(wy_reg);
        xl_raw         = col_reg + CW'(wx_reg);
        xr_raw         = d_reg + CW'(wx_reg);
        tag_now.head   = (wx_reg == -r_reg) && (wy_reg == -r_reg);
        tag_now.tail   = (wx_reg == r_reg) && (wy_reg == r_reg);
        tag_now.done   = tag_now.tail && (d_reg == hi_reg);
        tag_now.offset = sds_pkg::OFF_W'(d_reg - col_reg);
    end

    // sequencer and loop counters
    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        wx_next    = wx_reg;
        wy_next    = wy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                d_next     = lo;
                wx_next    = -r_reg;
                wy_next    = -r_reg;
                state_next = empty ? S_DONE : S_RUN;
            end
            S_RUN:
            begin
                if (wx_reg == r_reg)
                begin
                    wx_next = -r_reg;
                    if (wy_reg == r_reg)
                    begin
                        wy_next = -r_reg;
                        if (d_reg == hi_reg)
                            state_next = S_DRAIN;
                        else
                            d_next = d_reg + CW'(1);
                    end
                    else
                    begin
                        wy_next = wy_reg + RS'(1);
                    end
                end
                else
                begin
                    wx_next = wx_reg + RS'(1);
                end
            end
            S_DRAIN:
            begin
                if (fin)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_valid_reg <= (state_reg == S_RUN);
            b_valid_reg <= a_valid_reg;
        end
    end

    // query registers, counters and read address stages
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            col_reg <= CW'($signed({1'b0, q_col}));
            row_reg <= CW'($signed({1'b0, q_row}));
            wl1_reg <= wl1_next;
            hl1_reg <= hl1_next;
            r_reg   <= r_next;
        end
        if (state_reg == S_SETUP)
        begin
            hi_reg <= hi_next;
        end
        d_reg  <= d_next;
        wx_reg <= wx_next;
        wy_reg <= wy_next;

        a_y_reg   <= YW'(clamp_coord(y_raw, hl1_reg));
        a_xl_reg  <= XW'(clamp_coord(xl_raw, wl1_reg));
        a_xr_reg  <= XW'(clamp_coord(xr_raw, wl1_reg));
        a_tag_reg <= tag_now;

        b_addr_l_reg <= AW'(a_y_reg) * AW'(MAX_WIDTH) + AW'(a_xl_reg);
        b_addr_r_reg <= AW'(a_y_reg) * AW'(MAX_WIDTH) + AW'(a_xr_reg);
        b_tag_reg    <= a_tag_reg;
    end

    assign stat.ready = (state_reg == S_IDLE);
    assign stat.init  = (state_reg == S_SETUP);
    assign stat.load  = (state_reg == S_DONE) && slot_free;

    assign rd_valid  = b_valid_reg;
    assign rd_addr_l = b_addr_l_reg;
    assign rd_addr_r = b_addr_r_reg;
    assign rd_tag    = b_tag_reg;

endmodule

FILE: hdl/stereo_disparity_ssd.sv
// ----------------------------------------------------------------------------
// stereo_disparity_ssd
// SSD block-matching stereo disparity over two on-chip frame stores
// ----------------------------------------------------------------------------
// Items arrive on cmd. A write item (op 0) stores a left/right pixel pair at
// (col,row); pairs outside the stores are dropped.
// A query item (op 1) searches the candidate columns around (col,row) and
// returns one item on result: the best offset and its window SSD, or offset
// 0 with cost 99999999 when the candidate range is empty.
// A query over N candidate columns with radius R computes N*(2R+1)^2 squared
// differences, one per cycle from a single shared unit fed by one read port
// on each frame store.
// cmd.ready is low while a query runs. The result sits in an output register,
// so writes and a new query are taken while it waits; a query that finishes
// before the previous result is taken holds until the register frees.
// Configuration goes through the APB port; the user must write it only while idle; the block does not enforce it.
// Reset returns the registers to their defaults and empties the output; the
// frame stores are not cleared and must be written before they are queried.
module stereo_disparity_ssd #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_RADIUS = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    sds_cmd_if.sink      cmd,
    sds_result_if.source result
);

`include "stereo_disparity_ssd_macros.svh"

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    sds_pkg::cfg_t                    cfg_reg, cfg_next;
    sds_pkg::reg_idx_t                reg_idx;
    logic                             cfg_wr;

    sds_pkg::seq_stat_t               stat;
    logic                             accept, start, in_store, wr_en;
    logic [AW-1:0]                    wr_addr, addr_l, addr_r;
    logic                             rd_valid;
    logic [AW-1:0]                    rd_addr_l, rd_addr_r;
    sds_pkg::tag_t                    rd_tag;

    logic [sds_pkg::PIX_W-1:0]        px_l, px_r;
    logic                             mem_valid_reg;
    sds_pkg::tag_t                    mem_tag_reg;

    logic [sds_pkg::COST_W-1:0]       best_cost;
    logic signed [sds_pkg::OFF_W-1:0] best_off;
    logic                             fin;

    logic                             slot_free;
    logic                             out_valid_reg, out_valid_next;
    logic signed [sds_pkg::OFF_W-1:0] out_disp_reg;
    logic [sds_pkg::COST_W-1:0]       out_cost_reg;

    // configuration writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = sds_pkg::reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                sds_pkg::REG_RADIUS:     cfg_next.radius     = pwdata[sds_pkg::RADIUS_W-1:0];
                sds_pkg::REG_MIN_OFFSET: cfg_next.min_offset = $signed(pwdata[sds_pkg::OFF_W-1:0]);
                sds_pkg::REG_MAX_OFFSET: cfg_next.max_offset = $signed(pwdata[sds_pkg::OFF_W-1:0]);
                sds_pkg::REG_WIDTH:      cfg_next.width      = pwdata[sds_pkg::SIZE_W-1:0];
                sds_pkg::REG_HEIGHT:     cfg_next.height     = pwdata[sds_pkg::SIZE_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            sds_pkg::REG_RADIUS:     prdata = 32'(cfg_reg.radius);
            sds_pkg::REG_MIN_OFFSET: prdata = {24'd0, cfg_reg.min_offset};
            sds_pkg::REG_MAX_OFFSET: prdata = {24'd0, cfg_reg.max_offset};
            sds_pkg::REG_WIDTH:      prdata = 32'(cfg_reg.width);
            sds_pkg::REG_HEIGHT:     prdata = 32'(cfg_reg.height);
            default:                 prdata = '0;
        endcase
    end

    // input item decode
    assign cmd.ready = stat.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign start     = accept && (cmd.op == sds_pkg::OP_QUERY);
    assign in_store  = (int'(cmd.col) < MAX_WIDTH) && (int'(cmd.row) < MAX_HEIGHT);
    assign wr_en     = accept && (cmd.op == sds_pkg::OP_WRITE) && in_store;
    assign wr_addr   = AW'(cmd.row) * AW'(MAX_WIDTH) + AW'(cmd.col);
    assign addr_l    = wr_en ? wr_addr : rd_addr_l;
    assign addr_r    = wr_en ? wr_addr : rd_addr_r;

    sds_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .q_col     (cmd.col),
        .q_row     (cmd.row),
        .cfg       (cfg_reg),
        .fin       (fin),
        .slot_free (slot_free),
        .stat      (stat),
        .rd_valid  (rd_valid),
        .rd_addr_l (rd_addr_l),
        .rd_addr_r (rd_addr_r),
        .rd_tag    (rd_tag)
    );

    sds_frame_store #(
        .DEPTH (DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (wr_en),
        .addr  (addr_l),
        .wdata (cmd.left_pixel),
        .rdata (px_l)
    );

    sds_frame_store #(
        .DEPTH (DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (wr_en),
        .addr  (addr_r),
        .wdata (cmd.right_pixel),
        .rdata (px_r)
    );

    // marks follow the read data through the memory stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= 1'b0;
        end
        else
        begin
            mem_valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_tag_reg <= rd_tag;
    end

    sds_ssd_unit u_ssd (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (stat.init),
        .in_valid  (mem_valid_reg),
        .left_px   (px_l),
        .right_px  (px_r),
        .in_tag    (mem_tag_reg),
        .best_cost (best_cost),
        .best_off  (best_off),
        .fin       (fin)
    );

    // output register
    assign slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stat.load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= sds_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.load)
        begin
            out_disp_reg <= best_off;
            out_cost_reg <= best_cost;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.disparity = out_disp_reg;
    assign result.best_cost = out_cost_reg;

    // checks
    `SDS_ASSERT_IMPLY(a_idle_no_reads, clk, rst_n, cmd.ready, !rd_valid && !mem_valid_reg, "pixel read in flight while idle")
    `SDS_ASSERT_IMPLY(a_load_slot, clk, rst_n, stat.load, !out_valid_reg || result.ready, "result loaded over a waiting item")
    `SDS_ASSERT_NEXT(a_load_shows, clk, rst_n, stat.load, out_valid_reg, "loaded result not presented")
    `SDS_ASSERT_IMPLY(a_no_match_zero, clk, rst_n, out_valid_reg && (out_cost_reg == sds_pkg::NO_MATCH_COST), out_disp_reg == '0, "no-match result with nonzero offset")

endmodule
